@@ hw/rtl/datalog_token_scanner_unit_defines.svh @@
// Assertion macros for the datalog token scanner
`ifndef DATALOG_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define DATALOG_TOKEN_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define DTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/dtscan_pkg.sv @@
// Shared types, codes and character tables of the datalog token scanner
package dtscan_pkg;

   localparam int LINE_BITS_DEF   = 16;
   localparam int LENGTH_BITS_DEF = 16;
   localparam int OFFSET_BITS_DEF = 32;

   localparam int KIND_W   = 5;
   localparam int LINE_W   = 16;
   localparam int OFFSET_W = 32;
   localparam int LENGTH_W = 16;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_EOI  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_COMMA     = 5'd0;
   localparam logic [KIND_W-1:0] KIND_PERIOD    = 5'd1;
   localparam logic [KIND_W-1:0] KIND_QMARK     = 5'd2;
   localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd3;
   localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd4;
   localparam logic [KIND_W-1:0] KIND_COLON     = 5'd5;
   localparam logic [KIND_W-1:0] KIND_COLONDASH = 5'd6;
   localparam logic [KIND_W-1:0] KIND_MUL       = 5'd7;
   localparam logic [KIND_W-1:0] KIND_ADD       = 5'd8;
   localparam logic [KIND_W-1:0] KIND_KW_BASE   = 5'd8;
   localparam logic [KIND_W-1:0] KIND_ID        = 5'd13;
   localparam logic [KIND_W-1:0] KIND_STRING    = 5'd14;
   localparam logic [KIND_W-1:0] KIND_COMMENT   = 5'd15;
   localparam logic [KIND_W-1:0] KIND_UNDEF     = 5'd16;
   localparam logic [KIND_W-1:0] KIND_EOF       = 5'd17;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_PERIOD = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_BAR    = 8'h7C;

   typedef enum logic [2:0] {
      KW_NONE    = 3'd0,
      KW_SCHEMES = 3'd1,
      KW_FACTS   = 3'd2,
      KW_RULES   = 3'd3,
      KW_QUERIES = 3'd4
   } kw_type;

   localparam logic [7:0] KW_TEXT_SCHEMES [8] = '{"S", "c", "h", "e", "m", "e", "s", 8'h00};
   localparam logic [7:0] KW_TEXT_FACTS   [8] = '{"F", "a", "c", "t", "s", 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] KW_TEXT_RULES   [8] = '{"R", "u", "l", "e", "s", 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] KW_TEXT_QUERIES [8] = '{"Q", "u", "e", "r", "i", "e", "s", 8'h00};

   typedef enum logic [8:0] {
      MODE_IDLE  = 9'b000000001,
      MODE_IDENT = 9'b000000010,
      MODE_COLON = 9'b000000100,
      MODE_STR   = 9'b000001000,
      MODE_STRQ  = 9'b000010000,
      MODE_HASH  = 9'b000100000,
      MODE_LCOM  = 9'b001000000,
      MODE_BCOM  = 9'b010000000,
      MODE_BBAR  = 9'b100000000
   } mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [LINE_W-1:0]   line;
      logic [OFFSET_W-1:0] offset;
      logic [LENGTH_W-1:0] length;
      logic                last;
   } result_type;

   // results produced by one request, first one in r0
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

   function automatic logic is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
             c == CH_VT || c == CH_FF;
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_alnum(logic [7:0] c);
      return is_alpha(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic kw_type kw_guess_of(logic [7:0] c);
      kw_type g;
      unique case (c)
         "S":     g = KW_SCHEMES;
         "F":     g = KW_FACTS;
         "R":     g = KW_RULES;
         "Q":     g = KW_QUERIES;
         default: g = KW_NONE;
      endcase
      return g;
   endfunction

   function automatic logic [2:0] kw_len(kw_type g);
      logic [2:0] n;
      unique case (g)
         KW_SCHEMES, KW_QUERIES: n = 3'd7;
         KW_FACTS, KW_RULES:     n = 3'd5;
         default:                n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] kw_char(kw_type g, logic [2:0] i);
      logic [7:0] c;
      unique case (g)
         KW_SCHEMES: c = KW_TEXT_SCHEMES[i];
         KW_FACTS:   c = KW_TEXT_FACTS[i];
         KW_RULES:   c = KW_TEXT_RULES[i];
         KW_QUERIES: c = KW_TEXT_QUERIES[i];
         default:    c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

@@ hw/rtl/dtscan_req_if.sv @@
// Request channel: one character or an end-of-input mark
interface dtscan_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] ch;

   modport source (output valid, output op, output ch, input ready);
   modport sink   (input valid, input op, input ch, output ready);
endinterface

@@ hw/rtl/dtscan_rsp_if.sv @@
// Response channel: one token per transfer
interface dtscan_rsp_if;
   import dtscan_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   token_kind;
   logic [LINE_W-1:0]   start_line;
   logic [OFFSET_W-1:0] start_offset;
   logic [LENGTH_W-1:0] token_length;
   logic                last;

   modport source (output valid, output token_kind, output start_line, output start_offset,
                   output token_length, output last, input ready);
   modport sink   (input valid, input token_kind, input start_line, input start_offset,
                   input token_length, input last, output ready);
endinterface

@@ hw/rtl/dtscan_core.sv @@
// Scanner state machine: mode, pending token, keyword matcher, line and offset counters
module dtscan_core #(
   parameter int LINE_BITS   = dtscan_pkg::LINE_BITS_DEF,
   parameter int LENGTH_BITS = dtscan_pkg::LENGTH_BITS_DEF,
   parameter int OFFSET_BITS = dtscan_pkg::OFFSET_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic                op,
   input  logic [7:0]          ch,
   output dtscan_pkg::push_type push
);
   import dtscan_pkg::*;

   mode_type               mode_ff, mode_in;
   logic [LENGTH_BITS-1:0] plen_ff, plen_in;
   logic [LINE_BITS-1:0]   pline_ff, pline_in;
   logic [OFFSET_BITS-1:0] poff_ff, poff_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   kw_type                 guess_ff, guess_in;
   logic                   alive_ff, alive_in;

   // fresh start on the current character
   mode_type          f_mode;
   logic              f_begin;
   logic              f_emit;
   logic [KIND_W-1:0] f_kind;

   always_comb begin
      f_mode  = MODE_IDLE;
      f_begin = !is_blank(ch);
      f_emit  = 1'b0;
      f_kind  = KIND_UNDEF;
      if (is_blank(ch)) begin
         f_begin = 1'b0;
      end else if (is_alpha(ch)) begin
         f_mode = MODE_IDENT;
      end else begin
         unique case (ch)
            CH_COMMA:  begin f_emit = 1'b1; f_kind = KIND_COMMA;  end
            CH_PERIOD: begin f_emit = 1'b1; f_kind = KIND_PERIOD; end
            CH_QMARK:  begin f_emit = 1'b1; f_kind = KIND_QMARK;  end
            CH_LPAREN: begin f_emit = 1'b1; f_kind = KIND_LPAREN; end
            CH_RPAREN: begin f_emit = 1'b1; f_kind = KIND_RPAREN; end
            CH_STAR:   begin f_emit = 1'b1; f_kind = KIND_MUL;    end
            CH_PLUS:   begin f_emit = 1'b1; f_kind = KIND_ADD;    end
            CH_COLON:  f_mode = MODE_COLON;
            CH_QUOTE:  f_mode = MODE_STR;
            CH_HASH:   f_mode = MODE_HASH;
            default:   begin f_emit = 1'b1; f_kind = KIND_UNDEF;  end
         endcase
      end
   end

   logic [LENGTH_BITS-1:0] plen_grown;
   logic                   grow;
   logic [KIND_W-1:0]      ident_kind;

   assign plen_grown = (grow && plen_ff != '1) ? plen_ff + 1'b1 : plen_ff;

   always_comb begin
      ident_kind = KIND_ID;
      if (alive_ff && guess_ff != KW_NONE && plen_ff == LENGTH_BITS'(kw_len(guess_ff)))
         ident_kind = KIND_KW_BASE + {2'b00, guess_ff};
   end

   logic              do_fresh;
   logic              flush_v;
   logic [KIND_W-1:0] flush_kind;
   logic              new_v;
   logic [KIND_W-1:0] new_kind;
   logic              eoi;

   always_comb begin
      grow       = 1'b0;
      do_fresh   = 1'b0;
      flush_v    = 1'b0;
      flush_kind = KIND_UNDEF;
      mode_in    = mode_ff;
      alive_in   = alive_ff;
      eoi        = op == OP_EOI;
      if (!eoi) begin
         unique case (mode_ff)
            MODE_IDENT: begin
               if (is_alnum(ch)) begin
                  grow = 1'b1;
                  if (alive_ff && (guess_ff > KW_QUERIES ||
                                   plen_ff >= LENGTH_BITS'(kw_len(guess_ff)) ||
                                   kw_char(guess_ff, plen_ff[2:0]) != ch))
                     alive_in = 1'b0;
               end else begin
                  flush_v = 1'b1; flush_kind = ident_kind; do_fresh = 1'b1;
               end
            end
            MODE_COLON: begin
               flush_v = 1'b1;
               if (ch == CH_DASH) begin
                  grow = 1'b1; flush_kind = KIND_COLONDASH; mode_in = MODE_IDLE;
               end else begin
                  flush_kind = KIND_COLON; do_fresh = 1'b1;
               end
            end
            MODE_STR: begin
               grow = 1'b1;
               if (ch == CH_QUOTE) mode_in = MODE_STRQ;
            end
            MODE_STRQ: begin
               if (ch == CH_QUOTE) begin
                  grow = 1'b1; mode_in = MODE_STR;
               end else begin
                  flush_v = 1'b1; flush_kind = KIND_STRING; do_fresh = 1'b1;
               end
            end
            MODE_HASH: begin
               if (ch == CH_BAR) begin
                  grow = 1'b1; mode_in = MODE_BCOM;
               end else if (ch == CH_LF) begin
                  flush_v = 1'b1; flush_kind = KIND_COMMENT; do_fresh = 1'b1;
               end else begin
                  grow = 1'b1; mode_in = MODE_LCOM;
               end
            end
            MODE_LCOM: begin
               if (ch == CH_LF) begin
                  flush_v = 1'b1; flush_kind = KIND_COMMENT; do_fresh = 1'b1;
               end else begin
                  grow = 1'b1;
               end
            end
            MODE_BCOM: begin
               grow = 1'b1;
               if (ch == CH_BAR) mode_in = MODE_BBAR;
            end
            MODE_BBAR: begin
               grow = 1'b1;
               if (ch == CH_HASH) begin
                  flush_v = 1'b1; flush_kind = KIND_COMMENT; mode_in = MODE_IDLE;
               end else if (ch != CH_BAR) begin
                  mode_in = MODE_BCOM;
               end
            end
            default: do_fresh = 1'b1;
         endcase
         if (do_fresh) begin
            mode_in = (f_begin && f_emit) ? MODE_IDLE : f_mode;
            if (f_mode == MODE_IDENT) alive_in = kw_guess_of(ch) != KW_NONE;
         end
      end else begin
         unique case (mode_ff)
            MODE_IDENT:                     begin flush_v = 1'b1; flush_kind = ident_kind;   end
            MODE_COLON:                     begin flush_v = 1'b1; flush_kind = KIND_COLON;   end
            MODE_STRQ:                      begin flush_v = 1'b1; flush_kind = KIND_STRING;  end
            MODE_HASH, MODE_LCOM:           begin flush_v = 1'b1; flush_kind = KIND_COMMENT; end
            MODE_STR, MODE_BCOM, MODE_BBAR: begin flush_v = 1'b1; flush_kind = KIND_UNDEF;   end
            default:                        flush_v = 1'b0;
         endcase
         mode_in = MODE_IDLE;
      end
      new_v    = eoi || (do_fresh && f_emit);
      new_kind = eoi ? KIND_EOF : f_kind;
   end

   always_comb begin
      guess_in = guess_ff;
      pline_in = pline_ff;
      poff_in  = poff_ff;
      plen_in  = plen_grown;
      line_in  = line_ff;
      off_in   = off_ff + 1'b1;
      if (eoi) begin
         guess_in = KW_NONE;
         pline_in = LINE_BITS'(1);
         poff_in  = '0;
         plen_in  = '0;
         line_in  = LINE_BITS'(1);
         off_in   = '0;
      end else begin
         if (do_fresh && f_begin) begin
            pline_in = line_ff;
            poff_in  = off_ff;
            plen_in  = LENGTH_BITS'(1);
            if (f_mode == MODE_IDENT) guess_in = kw_guess_of(ch);
         end
         if (ch == CH_LF && line_ff != '1) line_in = line_ff + 1'b1;
      end
   end

   // fixed-width views of the counters for the result fields
   logic [LINE_BITS+LINE_W-1:0]     pline_x, line_x;
   logic [OFFSET_BITS+OFFSET_W-1:0] poff_x, off_x;
   logic [LENGTH_BITS+LENGTH_W-1:0] plen_x;

   assign pline_x = {{LINE_W{1'b0}}, pline_ff};
   assign line_x  = {{LINE_W{1'b0}}, line_ff};
   assign poff_x  = {{OFFSET_W{1'b0}}, poff_ff};
   assign off_x   = {{OFFSET_W{1'b0}}, off_ff};
   assign plen_x  = {{LENGTH_W{1'b0}}, plen_grown};

   result_type flush_res, new_res;

   always_comb begin
      flush_res.kind   = flush_kind;
      flush_res.line   = pline_x[LINE_W-1:0];
      flush_res.offset = poff_x[OFFSET_W-1:0];
      flush_res.length = plen_x[LENGTH_W-1:0];
      flush_res.last   = !new_v;
      new_res.kind     = new_kind;
      new_res.line     = line_x[LINE_W-1:0];
      new_res.offset   = off_x[OFFSET_W-1:0];
      new_res.length   = eoi ? LENGTH_W'(0) : LENGTH_W'(1);
      new_res.last     = 1'b1;
      push.r1          = new_res;
      if (flush_v) begin
         push.r0 = flush_res;
      end else begin
         push.r0 = new_res;
      end
      if (!take) begin
         push.count = 2'd0;
      end else begin
         push.count = {1'b0, flush_v} + {1'b0, new_v};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         plen_ff  <= '0;
         pline_ff <= LINE_BITS'(1);
         poff_ff  <= '0;
         line_ff  <= LINE_BITS'(1);
         off_ff   <= '0;
         guess_ff <= KW_NONE;
         alive_ff <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         plen_ff  <= plen_in;
         pline_ff <= pline_in;
         poff_ff  <= poff_in;
         line_ff  <= line_in;
         off_ff   <= off_in;
         guess_ff <= guess_in;
         alive_ff <= eoi ? 1'b0 : alive_in;
      end
   end

endmodule

@@ hw/rtl/dtscan_rspq.sv @@
// Token queue between the scanner and the response channel
module dtscan_rspq (
   input  logic                   clock,
   input  logic                   reset,
   input  dtscan_pkg::push_type   push,
   input  logic                   pop,
   output dtscan_pkg::result_type head,
   output logic                   head_valid,
   output logic                   space_ok
);
   import dtscan_pkg::*;

   result_type           q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ff, wr_in;
   logic [RSP_PTR_W-1:0] rd_ff, rd_in;
   logic [RSP_CNT_W-1:0] fill_ff, fill_in;
   logic [RSP_PTR_W-1:0] wr_next;

   assign wr_next    = wr_ff + 1'b1;
   assign head       = q_ff[rd_ff];
   assign head_valid = fill_ff != '0;
   // room for the two tokens one request may produce
   assign space_ok   = fill_ff <= RSP_CNT_W'(RSP_DEPTH - 2);

   always_comb begin
      wr_in   = wr_ff + RSP_PTR_W'(push.count);
      rd_in   = pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) q_ff[wr_ff] <= push.r0;
      if (push.count == 2'd2) q_ff[wr_next] <= push.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

@@ hw/rtl/datalog_token_scanner_unit.sv @@
// Datalog token scanner top level: scanner core and response queue
//
//   channel  dir  handshake     payload
//   req_bus  in   valid/ready   op, ch
//   rsp_bus  out  valid/ready   token_kind, start_line, start_offset, token_length, last
//
// One request per cycle while the queue has room; the scanner state updates on the accepting edge.
// Each request yields zero, one or two tokens, written into a four-entry queue
// that drains one token per cycle while rsp_bus is ready; requests stall while fewer than two entries are free.
// A token can appear on rsp_bus the cycle after its request is accepted.
// Synchronous reset returns the scanner to line 1, offset 0 and empties the queue.
`include "datalog_token_scanner_unit_defines.svh"

module datalog_token_scanner_unit #(
   parameter int LINE_BITS   = dtscan_pkg::LINE_BITS_DEF,
   parameter int LENGTH_BITS = dtscan_pkg::LENGTH_BITS_DEF,
   parameter int OFFSET_BITS = dtscan_pkg::OFFSET_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   dtscan_req_if.sink   req_bus,
   dtscan_rsp_if.source rsp_bus
);
   import dtscan_pkg::*;

   logic       take;
   logic       pop;
   logic       space_ok;
   logic       head_valid;
   push_type   push;
   result_type head;

   assign req_bus.ready = space_ok;
   assign take          = req_bus.valid && space_ok;
   assign pop           = head_valid && rsp_bus.ready;

   dtscan_core #(
      .LINE_BITS   (LINE_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .op    (req_bus.op),
      .ch    (req_bus.ch),
      .push  (push)
   );

   dtscan_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .space_ok   (space_ok)
   );

   assign rsp_bus.valid        = head_valid;
   assign rsp_bus.token_kind   = head.kind;
   assign rsp_bus.start_line   = head.line;
   assign rsp_bus.start_offset = head.offset;
   assign rsp_bus.token_length = head.length;
   assign rsp_bus.last         = head.last;

   `DTS_ASSERT_NEXT(a_eoi_gives_token, take && req_bus.op == OP_EOI, rsp_bus.valid, "end of input left no token queued")
   `DTS_ASSERT_NOW(a_push_needs_take, push.count != 2'd0, take, "token pushed without an accepted request")
   `DTS_ASSERT_NOW(a_pair_last_order, push.count == 2'd2, !push.r0.last && push.r1.last, "last flag misplaced on token pair")

endmodule

@@ sim/testbench.sv @@
// Testbench for the datalog token scanner: request driver, token predictor and token checker
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dtscan_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 500;
   localparam int HOLD_AT      = 300;
   localparam int DRAIN_CYCLES = 32;
   localparam int RANDOM_ITEMS = 1950;

   typedef struct packed {
      logic       op;
      logic [7:0] ch;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dtscan_req_if req_bus ();
   dtscan_rsp_if rsp_bus ();

   datalog_token_scanner_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.op    = OP_CHAR;
      req_bus.ch    = 8'h00;
      rsp_bus.ready = 1'b0;
   end

   request_type req_queue[$];
   result_type  expected_tokens[$];
   int unsigned error_count = 0;
   int unsigned token_count = 0;

   // ---------------------------------------------------------------------------------------
   // Token predictor
   // ---------------------------------------------------------------------------------------
   mode_type       scan_mode = MODE_IDLE;
   logic [15:0]    tok_len   = 16'd0;
   logic [15:0]    tok_line  = 16'd1;
   logic [31:0]    tok_off   = 32'd0;
   logic [15:0]    cur_line  = 16'd1;
   logic [31:0]    cur_off   = 32'd0;
   kw_type         kw_guess  = KW_NONE;
   logic           kw_alive  = 1'b0;
   result_type     step_tok[2];
   int             step_n;

   function automatic logic blank_char(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
             c == CH_VT || c == CH_FF;
   endfunction

   function automatic logic letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic alnum_char(logic [7:0] c);
      return letter(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic string keyword_spelling(kw_type g);
      case (g)
         KW_SCHEMES: return "Schemes";
         KW_FACTS:   return "Facts";
         KW_RULES:   return "Rules";
         KW_QUERIES: return "Queries";
         default:    return "";
      endcase
   endfunction

   task automatic restart_scan();
      scan_mode = MODE_IDLE;
      tok_len   = 16'd0;
      tok_line  = 16'd1;
      tok_off   = 32'd0;
      cur_line  = 16'd1;
      cur_off   = 32'd0;
      kw_guess  = KW_NONE;
      kw_alive  = 1'b0;
   endtask

   task automatic grow_token();
      if (tok_len != 16'hFFFF) tok_len = tok_len + 16'd1;
   endtask

   task automatic open_token();
      tok_line = cur_line;
      tok_off  = cur_off;
      tok_len  = 16'd1;
   endtask

   task automatic emit_token(logic [KIND_W-1:0] k);
      step_tok[step_n] = '{k, tok_line, tok_off, tok_len, 1'b0};
      step_n           = step_n + 1;
      scan_mode        = MODE_IDLE;
   endtask

   function automatic logic [KIND_W-1:0] word_kind();
      string sp;
      sp = keyword_spelling(kw_guess);
      if (kw_alive && kw_guess != KW_NONE && int'(tok_len) == sp.len())
         return KIND_KW_BASE + {2'b00, kw_guess};
      return KIND_ID;
   endfunction

   // character seen with no token open
   task automatic fresh_char(logic [7:0] c);
      scan_mode = MODE_IDLE;
      if (!blank_char(c)) begin
         open_token();
         if (letter(c)) begin
            scan_mode = MODE_IDENT;
            case (c)
               "S":     kw_guess = KW_SCHEMES;
               "F":     kw_guess = KW_FACTS;
               "R":     kw_guess = KW_RULES;
               "Q":     kw_guess = KW_QUERIES;
               default: kw_guess = KW_NONE;
            endcase
            kw_alive = kw_guess != KW_NONE;
         end else begin
            case (c)
               CH_COMMA:  emit_token(KIND_COMMA);
               CH_PERIOD: emit_token(KIND_PERIOD);
               CH_QMARK:  emit_token(KIND_QMARK);
               CH_LPAREN: emit_token(KIND_LPAREN);
               CH_RPAREN: emit_token(KIND_RPAREN);
               CH_STAR:   emit_token(KIND_MUL);
               CH_PLUS:   emit_token(KIND_ADD);
               CH_COLON:  scan_mode = MODE_COLON;
               CH_QUOTE:  scan_mode = MODE_STR;
               CH_HASH:   scan_mode = MODE_HASH;
               default:   emit_token(KIND_UNDEF);
            endcase
         end
      end
   endtask

   task automatic scan_char(logic [7:0] c);
      string sp;
      case (scan_mode)
         MODE_IDENT: begin
            if (alnum_char(c)) begin
               if (kw_alive) begin
                  sp = keyword_spelling(kw_guess);
                  if (int'(tok_len) >= sp.len() || sp[tok_len] != c) kw_alive = 1'b0;
               end
               grow_token();
            end else begin
               emit_token(word_kind());
               fresh_char(c);
            end
         end
         MODE_COLON: begin
            if (c == CH_DASH) begin
               grow_token();
               emit_token(KIND_COLONDASH);
            end else begin
               emit_token(KIND_COLON);
               fresh_char(c);
            end
         end
         MODE_STR: begin
            grow_token();
            if (c == CH_QUOTE) scan_mode = MODE_STRQ;
         end
         MODE_STRQ: begin
            // a second quote is an escaped quote, anything else closes the string
            if (c == CH_QUOTE) begin
               grow_token();
               scan_mode = MODE_STR;
            end else begin
               emit_token(KIND_STRING);
               fresh_char(c);
            end
         end
         MODE_HASH: begin
            if (c == CH_BAR) begin
               grow_token();
               scan_mode = MODE_BCOM;
            end else if (c == CH_LF) begin
               emit_token(KIND_COMMENT);
               fresh_char(c);
            end else begin
               grow_token();
               scan_mode = MODE_LCOM;
            end
         end
         MODE_LCOM: begin
            if (c == CH_LF) begin
               emit_token(KIND_COMMENT);
               fresh_char(c);
            end else begin
               grow_token();
            end
         end
         MODE_BCOM: begin
            grow_token();
            if (c == CH_BAR) scan_mode = MODE_BBAR;
         end
         MODE_BBAR: begin
            grow_token();
            if (c == CH_HASH) emit_token(KIND_COMMENT);
            else if (c != CH_BAR) scan_mode = MODE_BCOM;
         end
         default: fresh_char(c);
      endcase
      if (c == CH_LF && cur_line != 16'hFFFF) cur_line = cur_line + 16'd1;
      cur_off = cur_off + 32'd1;
   endtask

   task automatic predict_tokens(request_type r);
      step_n = 0;
      if (r.op == OP_CHAR) begin
         scan_char(r.ch);
      end else begin
         case (scan_mode)
            MODE_IDENT:            emit_token(word_kind());
            MODE_COLON:            emit_token(KIND_COLON);
            MODE_STRQ:             emit_token(KIND_STRING);
            MODE_HASH, MODE_LCOM:  emit_token(KIND_COMMENT);
            MODE_STR, MODE_BCOM,
            MODE_BBAR:             emit_token(KIND_UNDEF);
            default: ;
         endcase
         tok_line = cur_line;
         tok_off  = cur_off;
         tok_len  = 16'd0;
         emit_token(KIND_EOF);
         restart_scan();
      end
      if (step_n > 0) step_tok[step_n-1].last = 1'b1;
      for (int i = 0; i < step_n; i++)
         expected_tokens.insert(expected_tokens.size(), step_tok[i]);
   endtask

   // ---------------------------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps
   // ---------------------------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_tokens(req_queue[0]);
            req_queue.pop_front();
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the request until it is taken
         end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (req_queue.size() > 0) begin
            req_bus.valid <= 1'b1;
            req_bus.op    <= req_queue[0].op;
            req_bus.ch    <= req_queue[0].ch;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 30);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Token receiver: stall pattern changes by phase, one long hold-off
   // ---------------------------------------------------------------------------------------
   int unsigned rx_cycle  = 0;
   int unsigned rx_seen   = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;

   always @(posedge clock) begin
      logic rdy;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rx_cycle = rx_cycle + 1;
         if (rsp_bus.valid && rsp_bus.ready) rx_seen = rx_seen + 1;
         if (!hold_done && rx_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rdy = 1'b0;
         end else begin
            case ((rx_cycle / 300) % 4)
               0:       rdy = 1'b1;
               1:       rdy = 1'($urandom_range(0, 1));
               2:       rdy = $urandom_range(0, 7) != 0;
               default: rdy = (rx_cycle % 5) >= 2;
            endcase
         end
         rsp_bus.ready <= rdy;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Token checker
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.token_kind, rsp_bus.start_line, rsp_bus.start_offset,
                 rsp_bus.token_length, rsp_bus.last};
         if (expected_tokens.size() == 0) begin
            error_count = error_count + 1;
            if (error_count <= 10)
               $display("token %0d unexpected: kind %0d line %0d off %0d len %0d last %0b",
                        token_count, got.kind, got.line, got.offset, got.length, got.last);
         end else begin
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.line !== want.line ||
                got.offset !== want.offset || got.length !== want.length ||
                got.last !== want.last) begin
               error_count = error_count + 1;
               if (error_count <= 10) begin
                  $display("token %0d mismatch: expected kind %0d line %0d off %0d len %0d last %0b",
                           token_count, want.kind, want.line, want.offset, want.length,
                           want.last);
                  $display("   got kind %0d line %0d off %0d len %0d last %0b",
                           got.kind, got.line, got.offset, got.length, got.last);
               end
            end
         end
         token_count = token_count + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog: cycles with no transfer on either channel
   // ---------------------------------------------------------------------------------------
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   task automatic push_char(logic [7:0] c);
      req_queue.insert(req_queue.size(), request_type'{OP_CHAR, c});
   endtask

   task automatic push_eoi();
      req_queue.insert(req_queue.size(), request_type'{OP_EOI, 8'($urandom_range(0, 255))});
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(0, 3) == 0)
         case ($urandom_range(0, 3))
            0:       return "S";
            1:       return "F";
            2:       return "R";
            default: return "Q";
         endcase
      if ($urandom_range(0, 1) == 0) return 8'("A" + $urandom_range(0, 25));
      return 8'("a" + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_alnum();
      if ($urandom_range(0, 4) == 0) return 8'("0" + $urandom_range(0, 9));
      return rand_letter();
   endfunction

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(0, 9))
         0:       return CH_TAB;
         1, 2:    return CH_LF;
         3:       return CH_CR;
         4:       return CH_VT;
         5:       return CH_FF;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] rand_punct();
      case ($urandom_range(0, 6))
         0:       return CH_COMMA;
         1:       return CH_PERIOD;
         2:       return CH_QMARK;
         3:       return CH_LPAREN;
         4:       return CH_RPAREN;
         5:       return CH_STAR;
         default: return CH_PLUS;
      endcase
   endfunction

   // body text of strings and comments: mostly printable, some newlines and raw bytes
   function automatic logic [7:0] rand_body(logic [7:0] avoid);
      logic [7:0] c;
      case ($urandom_range(0, 11))
         0:       c = CH_LF;
         1:       c = 8'($urandom_range(0, 255));
         default: c = 8'($urandom_range(32, 126));
      endcase
      if (c == avoid) c = "z";
      return c;
   endfunction

   task automatic add_token();
      string sp;
      int    n;
      case ($urandom_range(0, 15))
         0, 1: push_char(rand_punct());
         2:    push_text(":-");
         3, 4: push_text(keyword_spelling(kw_type'($urandom_range(1, 4))));
         5: begin
            // near miss of a keyword: prefix, extension or one letter changed
            sp = keyword_spelling(kw_type'($urandom_range(1, 4)));
            case ($urandom_range(0, 2))
               0: push_text(sp.substr(0, $urandom_range(0, sp.len() - 2)));
               1: begin
                  push_text(sp);
                  repeat ($urandom_range(1, 3)) push_char(rand_alnum());
               end
               default: begin
                  sp.putc($urandom_range(1, sp.len() - 1), rand_alnum());
                  push_text(sp);
               end
            endcase
         end
         6, 7: begin
            push_char(rand_letter());
            repeat ($urandom_range(0, 8)) push_char(rand_alnum());
         end
         8, 9: begin
            push_char(CH_QUOTE);
            repeat ($urandom_range(0, 8))
               if ($urandom_range(0, 5) == 0) push_text("''");
               else push_char(rand_body(CH_QUOTE));
            push_char(CH_QUOTE);
         end
         10: begin
            push_char(CH_HASH);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) begin
               sp = "x";
               push_char(rand_body(i == 0 ? CH_BAR : CH_LF) == CH_LF ? "y" : rand_body(CH_LF));
            end
            push_char(CH_LF);
         end
         11: begin
            push_text("#|");
            repeat ($urandom_range(0, 10))
               case ($urandom_range(0, 5))
                  0:       push_char(CH_BAR);
                  1:       push_char(CH_HASH);
                  default: push_char(rand_body(CH_BAR));
               endcase
            if ($urandom_range(0, 2) == 0) push_text("||#");
            else push_text("|#");
         end
         12: push_char(8'("0" + $urandom_range(0, 9)));
         13: push_char(CH_COLON);
         14: push_text("#\n");
         default: begin
            case ($urandom_range(0, 2))
               0:       push_char(CH_DASH);
               1:       push_char(8'($urandom_range(128, 255)));
               default: push_char(8'($urandom_range(0, 8)));
            endcase
         end
      endcase
   endtask

   // text that ends with a token still open at end of input
   task automatic add_open_tail();
      case ($urandom_range(0, 6))
         0:       push_text("'ab");
         1:       push_text("'x'");
         2:       push_char(CH_COLON);
         3:       push_char(CH_HASH);
         4:       push_text("#|a\nb");
         5:       push_text("#|a|");
         default: push_text("#note");
      endcase
   endtask

   initial begin
      int base;
      int random_items;

      // directed: empty text, then every token kind with Facts as the only keyword, and the end-of-input corner cases
      push_eoi();
      push_text("Facts(x):-'a''b'.?*+#c\n9");
      push_eoi();
      push_char(CH_COMMA);
      push_char(8'hFF);
      push_char(8'h00);
      push_char(CH_COLON);
      push_eoi();
      push_char(CH_HASH);
      push_eoi();
      push_text("'a");
      push_eoi();
      push_text("#|");
      push_eoi();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         base = req_queue.size();
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 16)) push_char(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 14)) begin
               add_token();
               if ($urandom_range(0, 4) != 0) push_char(rand_blank());
            end
            if ($urandom_range(0, 5) == 0) add_open_tail();
         end
         push_eoi();
         random_items = random_items + (req_queue.size() - base);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (req_queue.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_tokens.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (expected_tokens.size() != 0)
            $display("%0d expected tokens never arrived", expected_tokens.size());
         $display("%0d errors", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
